@@ rtl/aff_pkg.sv @@
// ----------------------------------------------------------------------------
// aff_pkg
// Shared types and constants of the actuator frame feedback table.
// ----------------------------------------------------------------------------
package aff_pkg;

  localparam int JOINT_COUNT = 64;
  localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam logic [6:0] JOINT_MAX = 7'(JOINT_COUNT);

  localparam logic [10:0] MOTION_BASE = 11'h500;
  localparam logic [10:0] MOTION_LAST = 11'h540;
  localparam logic [10:0] STATUS_BASE = 11'h240;
  localparam logic [10:0] STATUS_LAST = 11'h280;

  localparam logic [3:0] MOTION_MIN_LEN = 4'd6;
  localparam logic [3:0] STATUS_MIN_LEN = 4'd8;

  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [1:0] KIND_IGNORED = 2'd0;
  localparam logic [1:0] KIND_MOTION  = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  // register select is address bit 3 (8-byte spacing)
  localparam logic REG_MASK  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [30:0] STALE_LIMIT_RESET = 31'd10000;

  typedef struct packed {
    logic [63:0] mask;
    logic [30:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             motion_we;
    logic             status_we;
    logic [IDX_W-1:0] idx;
    logic [55:0]      raw;
    logic [31:0]      stamp;
  } tbl_wr_t;

  typedef struct packed {
    logic [39:0] raw;
    logic [31:0] stamp;
    logic        valid;
  } motion_rec_t;

  typedef struct packed {
    logic [55:0] raw;
    logic [31:0] stamp;
    logic        valid;
  } status_rec_t;

  typedef struct packed {
    logic [20:0] fb_position;
    logic [22:0] fb_velocity;
    logic [21:0] fb_torque;
    logic        fb_stale;
    logic [26:0] st_position;
    logic [26:0] st_velocity;
    logic [26:0] st_torque;
    logic [7:0]  st_temperature;
    logic        st_stale;
  } feedback_t;

endpackage

@@ rtl/aff_cfg.sv @@
// ----------------------------------------------------------------------------
// aff_cfg
// APB register file: registered joint mask and stale age limit.
// ----------------------------------------------------------------------------
module aff_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output aff_pkg::cfg_t cfg
);
  import aff_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask  <= '0;
      cfg.limit <= STALE_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_MASK:  cfg.mask  <= pwdata;
        REG_LIMIT: cfg.limit <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_MASK:  prdata = cfg.mask;
      REG_LIMIT: prdata = {33'd0, cfg.limit};
      default:   prdata = '0;
    endcase
  end

endmodule

@@ rtl/aff_table.sv @@
// ----------------------------------------------------------------------------
// aff_table
// Motion and status record memories with per-entry valid bits.
// ----------------------------------------------------------------------------
module aff_table (
  input  logic                    clk,
  input  logic                    rst,
  input  aff_pkg::tbl_wr_t        wr,
  input  logic                    rd_en,
  input  logic [aff_pkg::IDX_W-1:0] rd_idx,
  output aff_pkg::motion_rec_t    motion,
  output aff_pkg::status_rec_t    status
);
  import aff_pkg::*;

  logic [71:0] motion_mem [JOINT_COUNT];
  logic [87:0] status_mem [JOINT_COUNT];
  logic [JOINT_COUNT-1:0] motion_valid;
  logic [JOINT_COUNT-1:0] status_valid;
  logic [71:0] motion_word;
  logic [87:0] status_word;
  logic        motion_vld;
  logic        status_vld;

  always_ff @(posedge clk) begin
    if (wr.motion_we) begin
      motion_mem[wr.idx] <= {wr.raw[39:0], wr.stamp};
    end
    if (wr.status_we) begin
      status_mem[wr.idx] <= {wr.raw, wr.stamp};
    end
    if (rd_en) begin
      motion_word <= motion_mem[rd_idx];
      status_word <= status_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_valid <= '0;
      status_valid <= '0;
      motion_vld   <= 1'b0;
      status_vld   <= 1'b0;
    end else begin
      if (wr.motion_we) begin
        motion_valid[wr.idx] <= 1'b1;
      end
      if (wr.status_we) begin
        status_valid[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        motion_vld <= motion_valid[rd_idx];
        status_vld <= status_valid[rd_idx];
      end
    end
  end

  assign motion.raw   = motion_word[71:32];
  assign motion.stamp = motion_word[31:0];
  assign motion.valid = motion_vld;
  assign status.raw   = status_word[87:32];
  assign status.stamp = status_word[31:0];
  assign status.valid = status_vld;

endmodule

@@ rtl/aff_convert.sv @@
// ----------------------------------------------------------------------------
// aff_convert
// Two-stage conversion of raw records to Q16 values and stale flags.
// ----------------------------------------------------------------------------
module aff_convert (
  input  logic                 clk,
  input  logic                 load,
  input  aff_pkg::motion_rec_t motion,
  input  aff_pkg::status_rec_t status,
  input  logic [31:0]          now,
  input  logic [30:0]          limit,
  output aff_pkg::feedback_t   fb
);
  import aff_pkg::*;

  // pi/180 * 2^16 with 32 fraction bits, split at bit 21
  localparam logic [42:0] DEG_TO_Q16 = 43'd4912665105575;
  localparam logic [21:0] DEG_HI = DEG_TO_Q16[42:21];
  localparam logic [20:0] DEG_LO = DEG_TO_Q16[20:0];
  // current: mag*3*2^16/125 = 1572*mag + (108*mag + 62)/125, /125 by 2^-29 reciprocal
  localparam logic [44:0] CUR_MUL = 45'd463856544;
  localparam logic [44:0] CUR_ADD = 45'd266288016;

  function automatic logic [4:0] div65535_q(input logic [20:0] y);
    logic [4:0]  q0;
    logic [16:0] r;
    q0 = y[20:16];
    r  = {1'b0, y[15:0]} + {12'd0, q0};
    return (r >= 17'd65535) ? q0 + 5'd1 : q0;
  endfunction

  function automatic logic [10:0] div4095_q(input logic [22:0] y);
    logic [10:0] q0;
    logic [12:0] r;
    q0 = y[22:12];
    r  = {1'b0, y[11:0]} + {2'd0, q0};
    return (r >= 13'd4095) ? q0 + 11'd1 : q0;
  endfunction

  function automatic logic [16:0] magnitude(input logic [15:0] v);
    return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
  endfunction

  logic [15:0] pos_raw;
  logic [11:0] vel_raw;
  logic [11:0] tq_raw;
  logic [16:0] ang_mag;
  logic [16:0] spd_mag;
  logic [16:0] cur_mag;
  logic [31:0] m_age;
  logic [31:0] s_age;

  logic [20:0] base_pos;
  logic [22:0] base_vel;
  logic [21:0] base_tq;
  logic        m_valid;
  logic        m_stale;
  logic [38:0] ang_hi;
  logic [37:0] ang_lo;
  logic        ang_neg;
  logic [38:0] spd_hi;
  logic [37:0] spd_lo;
  logic        spd_neg;
  logic [44:0] cur_prod;
  logic [25:0] cur_base;
  logic        cur_neg;
  logic [7:0]  temp;
  logic        s_valid;
  logic        s_stale;

  assign pos_raw = {motion.raw[7:0], motion.raw[15:8]};
  assign vel_raw = {motion.raw[23:16], motion.raw[31:28]};
  assign tq_raw  = {motion.raw[27:24], motion.raw[39:32]};
  assign ang_mag = magnitude(status.raw[55:40]);
  assign spd_mag = magnitude(status.raw[39:24]);
  assign cur_mag = magnitude(status.raw[23:8]);
  assign m_age   = now - motion.stamp;
  assign s_age   = now - status.stamp;

  always_ff @(posedge clk) begin
    if (load) begin
      base_pos <= 21'({5'd0, pos_raw} * 21'd25);
      base_vel <= 23'({11'd0, vel_raw} * 23'd1440);
      base_tq  <= 22'({10'd0, tq_raw} * 22'd768);
      m_valid  <= motion.valid;
      m_stale  <= !motion.valid || (m_age > {1'b0, limit});
      ang_hi   <= 39'(ang_mag) * 39'(DEG_HI);
      ang_lo   <= 38'(ang_mag) * 38'(DEG_LO);
      ang_neg  <= status.raw[55];
      spd_hi   <= 39'(spd_mag) * 39'(DEG_HI);
      spd_lo   <= 38'(spd_mag) * 38'(DEG_LO);
      spd_neg  <= status.raw[39];
      cur_prod <= 45'(cur_mag) * CUR_MUL + CUR_ADD;
      cur_base <= 26'(cur_mag) * 26'd1572;
      cur_neg  <= status.raw[23];
      temp     <= status.raw[7:0];
      s_valid  <= status.valid;
      s_stale  <= !status.valid || (s_age > {1'b0, limit});
    end
  end

  logic [21:0] pos_u;
  logic [23:0] vel_u;
  logic [22:0] tq_u;
  logic [59:0] ang_full;
  logic [59:0] spd_full;
  logic [26:0] ang_u;
  logic [26:0] spd_u;
  logic [26:0] cur_u;

  always_comb begin
    pos_u    = {1'b0, base_pos} + 22'(div65535_q(base_pos + 21'd32767));
    vel_u    = {1'b0, base_vel} + 24'(div4095_q(base_vel + 23'd2047));
    tq_u     = {1'b0, base_tq} + 23'(div4095_q({1'b0, base_tq} + 23'd2047));
    ang_full = {ang_hi, 21'd0} + 60'(ang_lo) + 60'h80000000;
    spd_full = {spd_hi, 21'd0} + 60'(spd_lo) + 60'h80000000;
    ang_u    = ang_full[58:32];
    spd_u    = spd_full[58:32];
    cur_u    = {1'b0, cur_base} + 27'(cur_prod[44:29]);

    fb.fb_position    = m_valid ? 21'(pos_u - 22'd819200) : '0;
    fb.fb_velocity    = m_valid ? 23'(vel_u - 24'd2949120) : '0;
    fb.fb_torque      = m_valid ? 22'(tq_u - 23'd1572864) : '0;
    fb.fb_stale       = m_stale;
    fb.st_position    = !s_valid ? '0 : (ang_neg ? 27'd0 - ang_u : ang_u);
    fb.st_velocity    = !s_valid ? '0 : (spd_neg ? 27'd0 - spd_u : spd_u);
    fb.st_torque      = !s_valid ? '0 : (cur_neg ? 27'd0 - cur_u : cur_u);
    fb.st_temperature = s_valid ? temp : '0;
    fb.st_stale       = s_stale;
  end

endmodule

@@ rtl/actuator_frame_feedback_table_core.sv @@
// ----------------------------------------------------------------------------
// actuator_frame_feedback_table_core
// Per-joint store of motion replies and status frames with Q16 readout.
// ----------------------------------------------------------------------------
// One item is handled at a time: the table write on acceptance, the
// synchronous memory read, and two conversion stages that end in the
// output register. The next item is accepted as soon as the result is in
// that register; while the output still holds a result that is not taken,
// the item waits in the last stage. Valid bits clear at reset, so no
// clearing pass is needed.
module actuator_frame_feedback_table_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_id, frame_len, frame_data, joint, time_now, zero pad
  input  logic [119:0] s_tdata,
  // action
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // joint_out, fb_position, fb_velocity, fb_torque, fb_stale, st_position,
  // st_velocity, st_torque, st_temperature, st_stale, zero pad
  output logic [167:0] m_tdata,
  // kind
  output logic [1:0]   m_tuser
);
  import aff_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CV1  = 2'd2;
  localparam logic [1:0] S_CV2  = 2'd3;

  cfg_t        cfg;
  tbl_wr_t     wr;
  motion_rec_t motion;
  status_rec_t status;
  feedback_t   fb;

  logic [1:0]       state;
  logic [1:0]       kind;
  logic [6:0]       joint_sel;
  logic [IDX_W-1:0] idx;
  logic             bad_read;
  logic [31:0]      now;

  logic [10:0] in_id;
  logic [3:0]  in_len;
  logic [63:0] in_data;
  logic [6:0]  in_joint;
  logic [31:0] in_now;
  logic        accept;
  logic        m_win;
  logic        s_win;
  logic [6:0]  frame_j;
  logic [6:0]  frame_jm1;
  logic        j_ok;
  logic        j_reg;
  logic        hit_m;
  logic        hit_s;
  logic        rd_ok;
  logic [1:0]  kind_next;
  logic [6:0]  joint_next;
  logic [6:0]  idx_src;
  logic        out_load;
  feedback_t   res;

  aff_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign in_id    = s_tdata[10:0];
  assign in_len   = s_tdata[14:11];
  assign in_data  = s_tdata[78:15];
  assign in_joint = s_tdata[85:79];
  assign in_now   = s_tdata[117:86];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    m_win     = (in_id > MOTION_BASE) && (in_id <= MOTION_LAST);
    s_win     = (in_id > STATUS_BASE) && (in_id <= STATUS_LAST);
    frame_j   = m_win ? 7'(in_id - MOTION_BASE) : 7'(in_id - STATUS_BASE);
    frame_jm1 = frame_j - 7'd1;
    j_ok      = frame_j <= JOINT_MAX;
    j_reg     = cfg.mask[frame_jm1[5:0]];
    hit_m     = m_win && j_ok && j_reg && (in_len >= MOTION_MIN_LEN);
    hit_s     = s_win && j_ok && j_reg && (in_len >= STATUS_MIN_LEN);
    rd_ok     = (in_joint != 7'd0) && (in_joint <= JOINT_MAX);

    if (s_tuser == ACT_READ) begin
      kind_next  = KIND_READ;
      joint_next = rd_ok ? in_joint : 7'd0;
      idx_src    = in_joint - 7'd1;
    end else begin
      kind_next  = hit_m ? KIND_MOTION : (hit_s ? KIND_STATUS : KIND_IGNORED);
      joint_next = (hit_m || hit_s) ? frame_j : 7'd0;
      idx_src    = frame_jm1;
    end

    wr.motion_we = accept && (s_tuser == ACT_FRAME) && hit_m;
    wr.status_we = accept && (s_tuser == ACT_FRAME) && hit_s;
    wr.idx       = idx_src[IDX_W-1:0];
    wr.raw       = in_data[63:8];
    wr.stamp     = in_now;
  end

  aff_table u_table (
    .clk, .rst, .wr,
    .rd_en  (state == S_RD),
    .rd_idx (idx),
    .motion,
    .status
  );

  aff_convert u_convert (
    .clk,
    .load   (state == S_CV1),
    .motion,
    .status,
    .now,
    .limit  (cfg.limit),
    .fb
  );

  assign out_load = (state == S_CV2) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_RD;
        end
        S_RD:   state <= S_CV1;
        S_CV1:  state <= S_CV2;
        S_CV2: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= kind_next;
      joint_sel <= joint_next;
      idx       <= idx_src[IDX_W-1:0];
      bad_read  <= (s_tuser == ACT_READ) && !rd_ok;
      now       <= in_now;
    end
  end

  always_comb begin
    res = fb;
    case (kind)
      KIND_IGNORED: res = '0;
      default: begin
        if (bad_read) begin
          res          = '0;
          res.fb_stale = 1'b1;
          res.st_stale = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= kind;
      m_tdata <= {4'd0, res.st_stale, res.st_temperature, res.st_torque,
                  res.st_velocity, res.st_position, res.fb_stale, res.fb_torque,
                  res.fb_velocity, res.fb_position, joint_sel};
    end
  end

endmodule

@@ rtl/aff_checker.sv @@
// ----------------------------------------------------------------------------
// aff_checker
// Port-level checks of the feedback table core, bound to the top level.
// ----------------------------------------------------------------------------
module aff_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [167:0] m_tdata,
  input logic [1:0]   m_tuser
);
  import aff_pkg::*;

  // one item in flight: no back-to-back acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous item still in work");

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_IGNORED) |-> (m_tdata == '0))
    else $error("ignored frame carries nonzero fields");

  a_bad_read_stale: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_READ) && (m_tdata[6:0] == 7'd0)
      |-> m_tdata[73] && m_tdata[163])
    else $error("out of range read without both stale flags");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result item changed");

endmodule

bind actuator_frame_feedback_table_core aff_checker u_aff_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ sim/actuator_frame_feedback_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// actuator_frame_feedback_table_core_tb
// Self-checking bench for the per-joint motion/status feedback table.
// A directed table covers reset contents, window edges, short frames,
// value extremes and the stale age test across wraparound. Random phases
// follow with mostly well-formed frames and reads under varied mask and
// age limit settings and varied idle patterns on both stream sides. Every
// result is checked against its fixed expected reply or an in-bench model
// of the table and its Q16 conversions.
// ----------------------------------------------------------------------------
module actuator_frame_feedback_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aff_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 260;
  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned DEG_Q32 = 64'd4912665105575;

  typedef struct packed {
    logic        act;
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic [6:0]  joint;
    logic [31:0] now;
  } stim_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] joint_out;
    feedback_t  v;
  } reply_t;

  typedef struct {
    bit     typed;
    reply_t want;
  } fixed_answer_t;

  typedef enum {PLAN_ITEM, PLAN_REG} plan_op_t;

  typedef struct {
    plan_op_t    op;
    stim_t       it;
    bit          typed;
    reply_t      want;
    logic        sel;
    logic [63:0] val;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // frame_id, frame_len, frame_data, joint, time_now, zero pad
  logic [119:0] s_tdata = '0;
  // action
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // joint_out, fb_position, fb_velocity, fb_torque, fb_stale, st_position,
  // st_velocity, st_torque, st_temperature, st_stale, zero pad
  logic [167:0] m_tdata;
  // kind
  logic [1:0]   m_tuser;

  actuator_frame_feedback_table_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  logic [39:0] mo_raw [64];
  logic [31:0] mo_time [64];
  bit          mo_ok [64];
  logic [55:0] st_raw [64];
  logic [31:0] st_time [64];
  bit          st_ok [64];
  logic [63:0] joint_mask = '0;
  logic [30:0] age_limit = STALE_LIMIT_RESET;

  reply_t        expected_replies [$];
  fixed_answer_t fixed_answers [$];
  plan_row_t     plan [$];
  int            err_count = 0;
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;
  int            pressure_req = 0;
  int            pressure_seen = 0;
  int            hold_left = 0;
  logic [31:0]   now_cursor = '0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic [26:0] deg_q16(logic [15:0] raw);
    longint sv;
    longint unsigned m;
    longint q;
    sv = $signed(raw);
    m = (sv < 0) ? -sv : sv;
    q = (m * DEG_Q32 + 64'h8000_0000) >> 32;
    q = (sv < 0) ? -q : q;
    return q[26:0];
  endfunction

  function automatic logic [26:0] amp_q16(logic [15:0] raw);
    longint sv;
    longint unsigned m;
    longint q;
    sv = $signed(raw);
    m = (sv < 0) ? -sv : sv;
    q = rdiv(m * 64'd196608, 64'd125);
    q = (sv < 0) ? -q : q;
    return q[26:0];
  endfunction

  function automatic feedback_t table_lookup(int i, logic [31:0] now);
    feedback_t   v;
    logic [39:0] m;
    logic [55:0] s;
    logic [15:0] pos;
    logic [11:0] vel;
    logic [11:0] tq;
    logic [31:0] age;
    longint      t;
    v = '0;
    if (mo_ok[i]) begin
      m = mo_raw[i];
      pos = {m[7:0], m[15:8]};
      vel = {m[23:16], m[31:28]};
      tq = {m[27:24], m[39:32]};
      t = longint'(rdiv(pos * 64'd1638400, 64'd65535)) - 819200;
      v.fb_position = t[20:0];
      t = longint'(rdiv(vel * 64'd5898240, 64'd4095)) - 2949120;
      v.fb_velocity = t[22:0];
      t = longint'(rdiv(tq * 64'd3145728, 64'd4095)) - 1572864;
      v.fb_torque = t[21:0];
    end
    age = now - mo_time[i];
    v.fb_stale = !mo_ok[i] || (age > {1'b0, age_limit});
    if (st_ok[i]) begin
      s = st_raw[i];
      v.st_position = deg_q16(s[55:40]);
      v.st_velocity = deg_q16(s[39:24]);
      v.st_torque = amp_q16(s[23:8]);
      v.st_temperature = s[7:0];
    end
    age = now - st_time[i];
    v.st_stale = !st_ok[i] || (age > {1'b0, age_limit});
    return v;
  endfunction

  function automatic reply_t predict_reply(stim_t it);
    reply_t r;
    bit     is_mo;
    bit     is_st;
    int     j;
    r = '0;
    if (it.act == ACT_READ) begin
      r.kind = KIND_READ;
      if (it.joint >= 1 && it.joint <= JOINT_MAX) begin
        r.joint_out = it.joint;
        r.v = table_lookup(int'(it.joint) - 1, it.now);
      end else begin
        r.v.fb_stale = 1'b1;
        r.v.st_stale = 1'b1;
      end
      return r;
    end
    is_mo = it.id > MOTION_BASE && it.id <= MOTION_LAST;
    is_st = it.id > STATUS_BASE && it.id <= STATUS_LAST;
    if (!is_mo && !is_st) return r;
    j = is_mo ? int'(it.id) - int'(MOTION_BASE) : int'(it.id) - int'(STATUS_BASE);
    if (j < 1 || j > JOINT_COUNT) return r;
    if (!joint_mask[j-1]) return r;
    if (is_mo) begin
      if (it.len < MOTION_MIN_LEN) return r;
      mo_raw[j-1] = it.data[47:8];
      mo_time[j-1] = it.now;
      mo_ok[j-1] = 1'b1;
      r.kind = KIND_MOTION;
    end else begin
      if (it.len < STATUS_MIN_LEN) return r;
      st_raw[j-1] = it.data[63:8];
      st_time[j-1] = it.now;
      st_ok[j-1] = 1'b1;
      r.kind = KIND_STATUS;
    end
    r.joint_out = 7'(j);
    r.v = table_lookup(j - 1, it.now);
    return r;
  endfunction

  function automatic reply_t plain_reply(logic [1:0] kind, logic [6:0] joint, logic stale);
    reply_t r;
    r = '0;
    r.kind = kind;
    r.joint_out = joint;
    r.v.fb_stale = stale;
    r.v.st_stale = stale;
    return r;
  endfunction

  function automatic stim_t mk_read(logic [6:0] joint, logic [31:0] now);
    stim_t it;
    it = '0;
    it.act = ACT_READ;
    it.joint = joint;
    it.now = now;
    return it;
  endfunction

  function automatic stim_t mk_frame(logic [10:0] id, logic [3:0] len, logic [63:0] data,
                                     logic [31:0] now);
    stim_t it;
    it = '0;
    it.act = ACT_FRAME;
    it.id = id;
    it.len = len;
    it.data = data;
    it.now = now;
    return it;
  endfunction

  function automatic void push_item(stim_t it);
    plan_row_t row;
    row = '{op: PLAN_ITEM, it: it, typed: 1'b0, want: '0, sel: 1'b0, val: '0};
    plan.push_back(row);
  endfunction

  function automatic void push_fixed(stim_t it, reply_t want);
    plan_row_t row;
    row = '{op: PLAN_ITEM, it: it, typed: 1'b1, want: want, sel: 1'b0, val: '0};
    plan.push_back(row);
  endfunction

  function automatic void push_reg(logic sel, logic [63:0] val);
    plan_row_t row;
    row = '{op: PLAN_REG, it: '0, typed: 1'b0, want: '0, sel: sel, val: val};
    plan.push_back(row);
  endfunction

  function automatic stim_t random_item();
    stim_t it;
    int    roll;
    int    j;
    roll = $urandom_range(1, 100);
    if ($urandom_range(1, 100) <= 95) now_cursor = now_cursor + $urandom_range(0, 2500);
    else now_cursor = $urandom;
    j = $urandom_range(1, 64);
    it.act = ACT_FRAME;
    it.id = 11'($urandom_range(0, 2047));
    it.len = 4'($urandom_range(0, 15));
    it.data = {$urandom, $urandom};
    it.joint = 7'($urandom_range(1, 64));
    it.now = now_cursor;
    if (roll <= 40) begin
      it.act = ACT_READ;
      if ($urandom_range(1, 10) == 1) it.joint = 7'($urandom_range(0, 127));
    end else if (roll <= 65) begin
      it.id = MOTION_BASE + 11'(j);
      it.len = 4'($urandom_range(6, 15));
    end else if (roll <= 88) begin
      it.id = STATUS_BASE + 11'(j);
      it.len = 4'($urandom_range(8, 15));
    end else if (roll <= 94) begin
      it.id = ($urandom_range(0, 1) ? MOTION_BASE : STATUS_BASE) +
              11'($urandom_range(0, 65));
    end
    return it;
  endfunction

  task automatic send_item(stim_t it, bit typed, reply_t want);
    fixed_answer_t fa;
    fa.typed = typed;
    fa.want = want;
    while ($urandom_range(1, 100) <= src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    fixed_answers.push_back(fa);
    s_tvalid <= 1'b1;
    s_tuser <= it.act;
    s_tdata <= {2'b0, it.now, it.joint, it.data, it.len, it.id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  task automatic write_reg(logic sel, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_MASK) joint_mask = val;
    else age_limit = val[30:0];
    @(posedge clk);
  endtask

  task automatic note_mismatch(reply_t want, reply_t got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch @%0t: kind %0d/%0d joint %0d/%0d fb %h/%h st %h/%h", $realtime,
               want.kind, got.kind, want.joint_out, got.joint_out,
               {want.v.fb_position, want.v.fb_velocity, want.v.fb_torque, want.v.fb_stale},
               {got.v.fb_position, got.v.fb_velocity, got.v.fb_torque, got.v.fb_stale},
               {want.v.st_position, want.v.st_velocity, want.v.st_torque,
                want.v.st_temperature, want.v.st_stale},
               {got.v.st_position, got.v.st_velocity, got.v.st_torque,
                got.v.st_temperature, got.v.st_stale});
  endtask

  always @(posedge clk) begin
    if (pressure_seen != pressure_req) begin
      pressure_seen = pressure_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(1, 100) > snk_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    reply_t        got;
    reply_t        want;
    stim_t         it;
    fixed_answer_t fa;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.joint_out = m_tdata[6:0];
        got.v.fb_position = m_tdata[27:7];
        got.v.fb_velocity = m_tdata[50:28];
        got.v.fb_torque = m_tdata[72:51];
        got.v.fb_stale = m_tdata[73];
        got.v.st_position = m_tdata[100:74];
        got.v.st_velocity = m_tdata[127:101];
        got.v.st_torque = m_tdata[154:128];
        got.v.st_temperature = m_tdata[162:155];
        got.v.st_stale = m_tdata[163];
        if (expected_replies.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result @%0t: kind %0d joint %0d", $realtime,
                     got.kind, got.joint_out);
        end else begin
          want = expected_replies.pop_front();
          if (want.kind !== got.kind || want.joint_out !== got.joint_out ||
              want.v.fb_position !== got.v.fb_position ||
              want.v.fb_velocity !== got.v.fb_velocity ||
              want.v.fb_torque !== got.v.fb_torque ||
              want.v.fb_stale !== got.v.fb_stale ||
              want.v.st_position !== got.v.st_position ||
              want.v.st_velocity !== got.v.st_velocity ||
              want.v.st_torque !== got.v.st_torque ||
              want.v.st_temperature !== got.v.st_temperature ||
              want.v.st_stale !== got.v.st_stale)
            note_mismatch(want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        it.act = s_tuser;
        it.id = s_tdata[10:0];
        it.len = s_tdata[14:11];
        it.data = s_tdata[78:15];
        it.joint = s_tdata[85:79];
        it.now = s_tdata[117:86];
        fa = fixed_answers.pop_front();
        want = predict_reply(it);
        expected_replies.push_back(fa.typed ? fa.want : want);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int          p;
    int          n;
    logic [63:0] mask_val;
    logic [30:0] limit_val;
    int          src_pcts [4];
    int          snk_pcts [4];
    src_pcts = '{0, 53, 0, 11};
    snk_pcts = '{0, 0, 53, 11};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset contents, bad joints, unregistered joint
    push_fixed(mk_read(7'd1, 32'd0), plain_reply(KIND_READ, 7'd1, 1'b1));
    push_fixed(mk_read(7'd64, 32'd0), plain_reply(KIND_READ, 7'd64, 1'b1));
    push_fixed(mk_read(7'd0, 32'd0), plain_reply(KIND_READ, 7'd0, 1'b1));
    push_fixed(mk_read(7'd127, 32'd0), plain_reply(KIND_READ, 7'd0, 1'b1));
    push_fixed(mk_frame(MOTION_BASE + 11'd1, 4'd8, '1, 32'd0),
               plain_reply(KIND_IGNORED, 7'd0, 1'b0));
    push_reg(REG_MASK, '1);
    push_reg(REG_LIMIT, 64'd0);
    // window edges, short frames, unrelated identifier
    push_fixed(mk_frame(MOTION_BASE, 4'd8, '1, 32'd0), plain_reply(KIND_IGNORED, 7'd0, 1'b0));
    push_fixed(mk_frame(STATUS_BASE, 4'd8, '1, 32'd0), plain_reply(KIND_IGNORED, 7'd0, 1'b0));
    push_fixed(mk_frame(MOTION_BASE + 11'd1, 4'd5, '1, 32'd0),
               plain_reply(KIND_IGNORED, 7'd0, 1'b0));
    push_fixed(mk_frame(STATUS_BASE + 11'd1, 4'd7, '1, 32'd0),
               plain_reply(KIND_IGNORED, 7'd0, 1'b0));
    push_fixed(mk_frame(MOTION_LAST + 11'd1, 4'd8, '1, 32'd0),
               plain_reply(KIND_IGNORED, 7'd0, 1'b0));
    push_fixed(mk_frame(11'h7FF, 4'd15, '1, 32'd0), plain_reply(KIND_IGNORED, 7'd0, 1'b0));
    // value extremes
    push_item(mk_frame(MOTION_BASE + 11'd1, 4'd6, '0, 32'd100));
    push_item(mk_frame(MOTION_LAST, 4'd15, '1, 32'd100));
    push_item(mk_frame(STATUS_BASE + 11'd1, 4'd8, 64'h8000_8000_8000_8000, 32'd100));
    push_item(mk_frame(STATUS_LAST, 4'd12, 64'h7FFF_7FFF_7FFF_7F00, 32'd100));
    // age limit zero, then maximum, then wraparound
    push_item(mk_read(7'd1, 32'd100));
    push_item(mk_read(7'd1, 32'd101));
    push_reg(REG_LIMIT, 64'h7FFF_FFFF);
    push_item(mk_read(7'd64, 32'd100 + 32'h7FFF_FFFF));
    push_item(mk_read(7'd64, 32'd100 + 32'h8000_0000));
    push_item(mk_frame(MOTION_BASE + 11'd2, 4'd8, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFF0));
    push_item(mk_read(7'd2, 32'h0000_0010));
    push_fixed(mk_read(7'd3, 32'd0), plain_reply(KIND_READ, 7'd3, 1'b1));
    push_reg(REG_LIMIT, 64'(STALE_LIMIT_RESET));
    push_item(mk_frame(STATUS_BASE + 11'd2, 4'd8, 64'hFEDC_BA98_7654_3210, 32'd5000));
    push_item(mk_read(7'd2, 32'd5000));

    foreach (plan[k]) begin
      if (plan[k].op == PLAN_REG) begin
        wait_drain();
        write_reg(plan[k].sel, plan[k].val);
      end else begin
        send_item(plan[k].it, plan[k].typed, plan[k].want);
      end
    end

    for (p = 0; p < 4; p++) begin
      wait_drain();
      case (p)
        0: begin
          mask_val = '1;
          limit_val = STALE_LIMIT_RESET;
        end
        1: begin
          mask_val = {$urandom, $urandom};
          limit_val = 31'($urandom_range(0, 4000));
        end
        2: begin
          mask_val = {$urandom, $urandom} | {$urandom, $urandom};
          limit_val = 31'h7FFF_FFFF;
        end
        default: begin
          mask_val = '1;
          limit_val = 31'($urandom);
        end
      endcase
      write_reg(REG_MASK, mask_val);
      write_reg(REG_LIMIT, 64'(limit_val));
      src_idle_pct = src_pcts[p];
      snk_stall_pct = snk_pcts[p];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 30) pressure_req++;
        send_item(random_item(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aff_pkg.sv
rtl/aff_cfg.sv
rtl/aff_table.sv
rtl/aff_convert.sv
rtl/actuator_frame_feedback_table_core.sv
rtl/aff_checker.sv
sim/actuator_frame_feedback_table_core_tb.sv
